FILE: rtl/joystick_motor_ramp_macros.svh
// -----------------------------------------------------------------------------
// joystick_motor_ramp_macros
// Assertion macros shared by the joystick motor ramp RTL; empty for synthesis.
// -----------------------------------------------------------------------------
`ifndef JOYSTICK_MOTOR_RAMP_MACROS_SVH
`define JOYSTICK_MOTOR_RAMP_MACROS_SVH
`ifndef SYNTHESIS
// condition that holds at every clock edge outside reset
`define JMR_ASSERT_ALW(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// same-cycle implication
`define JMR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define JMR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define JMR_ASSERT_ALW(label, clk, rst, cond)
`define JMR_ASSERT_IMP(label, clk, rst, ante, cons)
`define JMR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/jmr_pkg.sv
// -----------------------------------------------------------------------------
// jmr_pkg
// Widths and word types shared by the averaging pipeline and the ramp stage.
// -----------------------------------------------------------------------------
package jmr_pkg;

   localparam int ELAPSED_W = 16;
   localparam int DRIVE_W   = 12;
   localparam int DZL_W     = 13;
   localparam int DZH_W     = 12;

   localparam logic [DRIVE_W-1:0] DRIVE_MAX = 12'd4095;

   // deadzone bounds, low is two's complement
   typedef struct packed {
      logic [DZL_W-1:0] low;
      logic [DZH_W-1:0] high;
   } jmr_dz_type;

   // averaged and centred word handed to the ramp stage
   typedef struct packed {
      logic                 neg;
      logic                 pos;
      logic [DRIVE_W-1:0]   target;
      logic [ELAPSED_W-1:0] elapsed;
   } jmr_item_type;

endpackage

FILE: rtl/jmr_avg.sv
// -----------------------------------------------------------------------------
// jmr_avg
// Moving-average window in a read-first memory, running sum, reciprocal
// divide by the window length, centring, deadzone and target magnitude.
// -----------------------------------------------------------------------------
`include "joystick_motor_ramp_macros.svh"

module jmr_avg #(
   parameter int WINDOW_LEN  = 50,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [SAMPLE_BITS-1:0]         in_sample,
   input  logic [jmr_pkg::ELAPSED_W-1:0]  in_elapsed,
   input  jmr_pkg::jmr_dz_type            dz,
   output logic                           out_valid,
   input  logic                           out_ready,
   output jmr_pkg::jmr_item_type          out_item
);
   import jmr_pkg::*;

   localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LEN);
   localparam int PROD_W = 2 * SUM_W + 1;
   localparam int REM_W  = $clog2(2 * WINDOW_LEN);
   localparam int CW     = (SAMPLE_BITS + 2 > DZL_W) ? SAMPLE_BITS + 2 : DZL_W;
   localparam longint unsigned RECIP_L = (64'd1 << SUM_W) / WINDOW_LEN;
   localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'(RECIP_L);
   localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW_LEN * ((1 << SAMPLE_BITS) - 1));
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

   logic [SAMPLE_BITS-1:0] window_mem [WINDOW_LEN];
   logic [SAMPLE_BITS-1:0] rd_ff;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic                   wrapped_ff, wrapped_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;

   logic                   p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, p5_v_ff;
   logic                   rdy1, rdy2, rdy3, rdy4, rdy5;
   logic                   accept;

   logic [SAMPLE_BITS-1:0] p1_sample_ff;
   logic                   p1_wr_ff;
   logic [ELAPSED_W-1:0]   p1_el_ff, p2_el_ff, p3_el_ff, p4_el_ff;
   logic [SUM_W-1:0]       p2_sum_ff, p3_sum_ff;
   logic [PROD_W-1:0]      p3_prod_ff, prod_in;
   logic [SAMPLE_BITS-1:0] p4_qest_ff, qest_in, quot;
   logic [REM_W-1:0]       p4_rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] old_sample;
   jmr_item_type           p5_item_ff, item_in;

   logic signed [CW-1:0]   centred, dz_lo, dz_hi;
   logic [CW-1:0]          mag;
   logic                   in_dz;

   // ready chain, bubbles collapse
   assign rdy5     = !p5_v_ff || out_ready;
   assign rdy4     = !p4_v_ff || rdy5;
   assign rdy3     = !p3_v_ff || rdy4;
   assign rdy2     = !p2_v_ff || rdy3;
   assign rdy1     = !p1_v_ff || rdy2;
   assign in_ready = rdy1;
   assign accept   = in_valid && rdy1;

   // window memory, read-first
   always_ff @(posedge clock) begin
      if (accept) begin
         window_mem[slot_ff] <= in_sample;
         rd_ff               <= window_mem[slot_ff];
      end
   end

   always_comb begin
      slot_in    = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
      wrapped_in = wrapped_ff || (slot_ff == SLOT_LAST);
      old_sample = p1_wr_ff ? rd_ff : '0;
      sum_in     = sum_ff - SUM_W'(old_sample) + SUM_W'(p1_sample_ff);
      prod_in    = PROD_W'(p2_sum_ff) * PROD_W'(RECIP);
      qest_in    = SAMPLE_BITS'(p3_prod_ff >> SUM_W);
      rem_in     = REM_W'(p3_sum_ff - SUM_W'(qest_in) * SUM_W'(WINDOW_LEN));
      quot       = (p4_rem_ff >= REM_W'(WINDOW_LEN)) ? p4_qest_ff + 1'b1 : p4_qest_ff;
      centred    = ($signed(CW'(quot)) - $signed(CW'(1 << (SAMPLE_BITS - 1)))) <<< 1;
      dz_lo      = CW'($signed(dz.low));
      dz_hi      = $signed(CW'(dz.high));
      in_dz      = (centred >= dz_lo) && (centred <= dz_hi);
      mag        = (centred < 0) ? CW'(-centred) : CW'(centred);
      item_in.neg     = !in_dz && (centred < 0);
      item_in.pos     = !in_dz && (centred > 0);
      item_in.elapsed = p4_el_ff;
      if (in_dz) begin
         item_in.target = '0;
      end else if (mag > CW'(DRIVE_MAX)) begin
         item_in.target = DRIVE_MAX;
      end else begin
         item_in.target = DRIVE_W'(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         wrapped_ff <= 1'b0;
         sum_ff     <= '0;
         p1_v_ff    <= 1'b0;
         p2_v_ff    <= 1'b0;
         p3_v_ff    <= 1'b0;
         p4_v_ff    <= 1'b0;
         p5_v_ff    <= 1'b0;
      end else begin
         if (accept) begin
            slot_ff    <= slot_in;
            wrapped_ff <= wrapped_in;
         end
         if (p1_v_ff && rdy2) begin
            sum_ff <= sum_in;
         end
         if (rdy1) p1_v_ff <= in_valid;
         if (rdy2) p2_v_ff <= p1_v_ff;
         if (rdy3) p3_v_ff <= p2_v_ff;
         if (rdy4) p4_v_ff <= p3_v_ff;
         if (rdy5) p5_v_ff <= p4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_sample_ff <= in_sample;
         p1_el_ff     <= in_elapsed;
         p1_wr_ff     <= wrapped_ff;
      end
      if (rdy2) begin
         p2_sum_ff <= sum_in;
         p2_el_ff  <= p1_el_ff;
      end
      if (rdy3) begin
         p3_prod_ff <= prod_in;
         p3_sum_ff  <= p2_sum_ff;
         p3_el_ff   <= p2_el_ff;
      end
      if (rdy4) begin
         p4_qest_ff <= qest_in;
         p4_rem_ff  <= rem_in;
         p4_el_ff   <= p3_el_ff;
      end
      if (rdy5) begin
         p5_item_ff <= item_in;
      end
   end

   assign out_valid = p5_v_ff;
   assign out_item  = p5_item_ff;

   `JMR_ASSERT_ALW(a_slot_range, clock, reset, slot_ff <= SLOT_LAST)
   `JMR_ASSERT_ALW(a_sum_range, clock, reset, sum_ff <= SUM_MAX)
   `JMR_ASSERT_IMP(a_rem_range, clock, reset, p4_v_ff, {1'b0, p4_rem_ff} < (REM_W + 1)'(2 * WINDOW_LEN))
   `JMR_ASSERT_IMP(a_no_dir_in_dz, clock, reset, p5_v_ff && (p5_item_ff.target == '0), !p5_item_ff.neg && !p5_item_ff.pos)

endmodule

FILE: rtl/joystick_motor_ramp.sv
// -----------------------------------------------------------------------------
// joystick_motor_ramp
// Joystick axis to motor drive: moving average, deadzone, direction and a
// slew-limited drive level that steps toward the target once per interval.
//
//   port group   dir   payload                                  accept
//   req_         in    joystick_sample, elapsed_us              valid & !stall
//   rsp_         out   direction_forward, drive_duty            valid & !stall
//   csr_         in    wr_en, index, wdata (4 registers)        wr_en
//
// One word per cycle sustained while no result is stalled; a result passes the
// memory read, sum, reciprocal multiply, remainder fix, deadzone and then the
// ramp update, whose state closes on itself, on its way to the output register.
// After reset the window reads as zero through a wrap flag: no clearing pass.
// A stalled result holds in the output register; words with no result keep
// flowing past it and upstream stages fill their bubbles before req_stall.
// -----------------------------------------------------------------------------
`include "joystick_motor_ramp_macros.svh"

module joystick_motor_ramp #(
   parameter int WINDOW_LEN  = 50,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [SAMPLE_BITS-1:0]         req_joystick_sample,
   input  logic [jmr_pkg::ELAPSED_W-1:0]  req_elapsed_us,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_direction_forward,
   output logic [jmr_pkg::DRIVE_W-1:0]    rsp_drive_duty,
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_index,
   input  logic [19:0]                    csr_wdata
);
   import jmr_pkg::*;

   localparam int STEP_W     = 12;
   localparam int INTERVAL_W = 20;
   localparam int TIME_W     = INTERVAL_W + 1;

   localparam logic [1:0] CSR_STEP_SIZE     = 2'd0;
   localparam logic [1:0] CSR_STEP_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_DZ_LOW        = 2'd2;
   localparam logic [1:0] CSR_DZ_HIGH       = 2'd3;

   localparam logic [STEP_W-1:0]     STEP_RST     = 12'd40;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 20'd1000;
   localparam logic [DZL_W-1:0]      DZ_LOW_RST   = 13'h1FCE;
   localparam logic [DZH_W-1:0]      DZ_HIGH_RST  = 12'd150;

   logic [STEP_W-1:0]     step_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   jmr_dz_type            dz_ff;

   logic                  av_valid, av_ready, av_in_ready;
   jmr_item_type          av_item;

   logic [DRIVE_W-1:0]    level_ff, level_in;
   logic                  ramp_ff, ramp_in;
   logic [TIME_W-1:0]     tss_ff, tss_in, t_add;
   logic                  heading_ff, heading_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_dir_ff;
   logic [DRIVE_W-1:0]    rsp_drive_duty_ff;

   logic                  up, dn, sense_nz, step_go, done, ramp_fire, out_free;
   logic [DRIVE_W:0]      up_sum, dn_lim;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= STEP_RST;
         interval_ff <= INTERVAL_RST;
         dz_ff.low   <= DZ_LOW_RST;
         dz_ff.high  <= DZ_HIGH_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STEP_SIZE:     step_ff     <= csr_wdata[STEP_W-1:0];
            CSR_STEP_INTERVAL: interval_ff <= csr_wdata[INTERVAL_W-1:0];
            CSR_DZ_LOW:        dz_ff.low   <= csr_wdata[DZL_W-1:0];
            CSR_DZ_HIGH:       dz_ff.high  <= csr_wdata[DZH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   jmr_avg #(
      .WINDOW_LEN  (WINDOW_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_avg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (av_in_ready),
      .in_sample  (req_joystick_sample),
      .in_elapsed (req_elapsed_us),
      .dz         (dz_ff),
      .out_valid  (av_valid),
      .out_ready  (av_ready),
      .out_item   (av_item)
   );

   assign req_stall = !av_in_ready;

   // ramp update
   always_comb begin
      up       = av_item.target > level_ff;
      dn       = av_item.target < level_ff;
      sense_nz = up || dn;
      out_free = !rsp_valid_ff || !rsp_stall;
      av_ready = out_free || !sense_nz;
      ramp_fire = av_valid && av_ready;

      t_add   = ramp_ff ? tss_ff + TIME_W'(av_item.elapsed) : '0;
      step_go = ramp_ff && (t_add > TIME_W'(interval_ff));
      up_sum  = {1'b0, level_ff} + {1'b0, step_ff};
      dn_lim  = {1'b0, av_item.target} + {1'b0, step_ff};
      if (up) begin
         done = up_sum >= {1'b0, av_item.target};
      end else if (dn) begin
         done = {1'b0, level_ff} <= dn_lim;
      end else begin
         done = 1'b1;
      end

      level_in = level_ff;
      ramp_in  = ramp_ff || sense_nz;
      tss_in   = t_add;
      if (step_go) begin
         tss_in = '0;
         if (done) begin
            level_in = av_item.target;
            ramp_in  = 1'b0;
         end else if (up) begin
            level_in = up_sum[DRIVE_W-1:0];
         end else begin
            level_in = level_ff - step_ff;
         end
      end

      if (av_item.neg) begin
         heading_in = 1'b1;
      end else if (av_item.pos) begin
         heading_in = 1'b0;
      end else begin
         heading_in = heading_ff;
      end

      rsp_valid_in = (ramp_fire && sense_nz) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         ramp_ff      <= 1'b0;
         tss_ff       <= '0;
         heading_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ramp_fire) begin
            level_ff   <= level_in;
            ramp_ff    <= ramp_in;
            tss_ff     <= tss_in;
            heading_ff <= heading_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ramp_fire && sense_nz) begin
         rsp_dir_ff        <= heading_in;
         rsp_drive_duty_ff <= level_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_direction_forward = rsp_dir_ff;
   assign rsp_drive_duty        = rsp_drive_duty_ff;

   `JMR_ASSERT_IMP(a_idle_timer, clock, reset, !ramp_ff, tss_ff == '0)
   `JMR_ASSERT_IMP(a_rsp_level, clock, reset, rsp_valid_ff, rsp_drive_duty_ff == level_ff)
   `JMR_ASSERT_NXT(a_step_clears, clock, reset, ramp_fire && step_go, tss_ff == '0)
   `JMR_ASSERT_IMP(a_result_room, clock, reset, ramp_fire && sense_nz, out_free)

endmodule

FILE: tb/tb_joystick_motor_ramp.sv
// -----------------------------------------------------------------------------
// tb_joystick_motor_ramp
// Self-checking bench for the joystick motor ramp: joystick words go in with
// random gaps, drive words come back under random and long stalls, and each
// one is compared against a cycle-free model of the averaging window,
// deadzone, direction choice and slew-limited drive ramp.
// -----------------------------------------------------------------------------
module tb_joystick_motor_ramp;
   import jmr_pkg::*;

   localparam int WINDOW      = 50;
   localparam int HALF_SCALE  = 2048;
   localparam int DUTY_LIMIT  = 4095;
   localparam int SETTLE      = 10;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 5000;

   localparam logic [1:0] REG_STEP_SIZE     = 2'd0;
   localparam logic [1:0] REG_STEP_INTERVAL = 2'd1;
   localparam logic [1:0] REG_DZ_LOW        = 2'd2;
   localparam logic [1:0] REG_DZ_HIGH       = 2'd3;

   typedef struct packed {
      logic               forward;
      logic [DRIVE_W-1:0] duty;
   } drive_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [11:0]          req_joystick_sample = '0;
   logic [ELAPSED_W-1:0] req_elapsed_us = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_direction_forward;
   logic [DRIVE_W-1:0]   rsp_drive_duty;
   logic                 csr_wr_en = 1'b0;
   logic [1:0]           csr_index = '0;
   logic [19:0]          csr_wdata = '0;

   joystick_motor_ramp dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_joystick_sample   (req_joystick_sample),
      .req_elapsed_us        (req_elapsed_us),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_direction_forward (rsp_direction_forward),
      .rsp_drive_duty        (rsp_drive_duty),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #10 clock = ~clock;

   // model state
   logic [11:0]        window_mem [WINDOW];
   int                 window_total;
   int                 window_pos;
   logic               heading_fwd;
   int                 drive_now;
   int                 drive_sent;
   bit                 ramping;
   logic [31:0]        since_step;
   logic [11:0]        cfg_step;
   logic [19:0]        cfg_interval;
   logic signed [12:0] cfg_dz_low;
   logic [11:0]        cfg_dz_high;

   drive_word_type pending_drive [$];

   int words_sent    = 0;
   int words_checked = 0;
   int mismatches    = 0;
   int settings_used = 1;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   function automatic bit predict_drive(input logic [11:0] sample,
                                        input logic [ELAPSED_W-1:0] elapsed,
                                        output drive_word_type res);
      int         avg, centred, target, sense;
      logic [32:0] acc;
      bit         done;
      window_total = window_total - int'(window_mem[window_pos]) + int'(sample);
      window_mem[window_pos] = sample;
      window_pos = (window_pos + 1) % WINDOW;
      avg = window_total / WINDOW;
      centred = (avg - HALF_SCALE) * 2;
      if (centred >= int'(cfg_dz_low) && centred <= int'(cfg_dz_high))
         centred = 0;
      if (centred < 0)
         heading_fwd = 1'b1;
      else if (centred > 0)
         heading_fwd = 1'b0;
      target = (centred < 0) ? -centred : centred;
      if (target > DUTY_LIMIT)
         target = DUTY_LIMIT;
      sense = (target > drive_sent) ? 1 : ((target < drive_sent) ? -1 : 0);
      if (ramping) begin
         acc = {1'b0, since_step} + {17'd0, elapsed};
         since_step = acc[32] ? '1 : acc[31:0];
      end
      if (sense != 0 && !ramping) begin
         ramping = 1'b1;
         since_step = '0;
      end
      if (ramping && since_step > {12'd0, cfg_interval}) begin
         if (sense > 0) begin
            drive_now += int'(cfg_step);
            done = drive_now >= target;
         end else if (sense < 0) begin
            drive_now -= int'(cfg_step);
            done = drive_now <= target;
         end else begin
            done = 1'b1;
         end
         if (done) begin
            drive_now = target;
            ramping = 1'b0;
         end
         since_step = '0;
      end
      res.forward = heading_fwd;
      res.duty = drive_now[DRIVE_W-1:0];
      if (sense != 0)
         drive_sent = drive_now;
      return sense != 0;
   endfunction

   task automatic send_word(input logic [11:0] sample, input logic [ELAPSED_W-1:0] elapsed);
      drive_word_type res;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_joystick_sample <= sample;
      req_elapsed_us <= elapsed;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (predict_drive(sample, elapsed, res))
         pending_drive.push_back(res);
      words_sent++;
   endtask

   // drains the block, then writes all four registers
   task automatic apply_settings(input logic [11:0] step, input logic [19:0] interval,
                                 input logic signed [12:0] dz_low,
                                 input logic [11:0] dz_high);
      req_valid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= REG_STEP_SIZE;
      csr_wdata <= {8'd0, step};
      @(posedge clock);
      csr_index <= REG_STEP_INTERVAL;
      csr_wdata <= interval;
      @(posedge clock);
      csr_index <= REG_DZ_LOW;
      csr_wdata <= {7'd0, dz_low};
      @(posedge clock);
      csr_index <= REG_DZ_HIGH;
      csr_wdata <= {8'd0, dz_high};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_step = step;
      cfg_interval = interval;
      cfg_dz_low = dz_low;
      cfg_dz_high = dz_high;
      settings_used++;
   endtask

   // runs of near-constant samples so the average actually travels
   task automatic run_bursts(input int n_words);
      int                   left, run_len, level, s;
      logic [ELAPSED_W-1:0] gap_us;
      left = n_words;
      while (left > 0) begin
         case ($urandom_range(5))
            0:       level = 0;
            1:       level = DUTY_LIMIT;
            default: level = $urandom_range(DUTY_LIMIT);
         endcase
         run_len = $urandom_range(10, 90);
         for (int k = 0; k < run_len && left > 0; k++) begin
            if ($urandom_range(9) < 2) begin
               s = $urandom_range(DUTY_LIMIT);
            end else begin
               s = level + int'($urandom_range(64)) - 32;
               if (s < 0) s = 0;
               if (s > DUTY_LIMIT) s = DUTY_LIMIT;
            end
            case ($urandom_range(3))
               0:       gap_us = ELAPSED_W'($urandom_range(65535));
               1:       gap_us = ELAPSED_W'($urandom_range(50));
               default: gap_us = ELAPSED_W'($urandom_range(3000));
            endcase
            send_word(12'(s), gap_us);
            left--;
         end
      end
   endtask

   task automatic test_power_up;
      send_word(12'd0, 16'd0);
      send_word(12'd0, 16'd1000);
      send_word(12'd0, 16'd1001);
      send_word(12'd0, 16'hFFFF);
      send_word(12'hFFF, 16'hFFFF);
      send_word(12'hFFF, 16'd0);
      send_word(12'hFFF, 16'd2000);
   endtask

   // whole range in the deadzone forces a decel to zero with an oversized step
   task automatic test_fast_ramp_clamp;
      apply_settings(12'hFFF, 20'd0, -13'sd4096, 12'hFFF);
      repeat (3) send_word(12'hFFF, 16'd5);
      apply_settings(12'hFFF, 20'd0, -13'sd1, 12'd0);
      repeat (4) send_word(12'hFFF, 16'd5);
   endtask

   task automatic test_zero_step;
      apply_settings(12'd0, 20'd0, -13'sd50, 12'd150);
      repeat (4) send_word(12'd0, 16'd100);
   endtask

   // low bound above high bound: nothing is treated as centre
   task automatic test_inverted_deadzone;
      apply_settings(12'd40, 20'd1000, 13'sd100, 12'd0);
      repeat (4) send_word(12'd2048, 16'($urandom_range(65535)));
   endtask

   task automatic test_random_mix;
      logic [11:0]        step;
      logic [19:0]        interval;
      logic signed [12:0] dz_low;
      logic [11:0]        dz_high;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               step = 12'hFFF; interval = 20'd0; dz_low = -13'sd50; dz_high = 12'd150;
            end
            1: begin
               step = 12'd1; interval = 20'hFFFFF; dz_low = -13'sd4096; dz_high = 12'd0;
            end
            2: begin
               step = 12'($urandom_range(1, 300));
               interval = 20'($urandom_range(5000));
               dz_low = -13'($urandom_range(400));
               dz_high = 12'($urandom_range(400));
            end
            default: begin
               step = 12'($urandom_range(1, 4095));
               interval = 20'd1000;
               dz_low = 13'sh0FFF;
               dz_high = 12'hFFF;
            end
         endcase
         apply_settings(step, interval, dz_low, dz_high);
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 47; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 47; end
            default: begin send_idle_pct = 26; stall_pct <= 26; end
         endcase
         run_bursts(130);
      end
   endtask

   // receiver holds off while words keep coming, filling the pipe
   task automatic test_backpressure;
      apply_settings(12'd1, 20'd0, -13'sd50, 12'd150);
      send_idle_pct = 0;
      stall_pct <= 0;
      hold_requests <= hold_requests + 1;
      repeat (40) send_word(12'hFFF, 16'd10);
   endtask

   // receiver side, long hold-off counted here
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      drive_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_drive.size() == 0) begin
            $display("%0t: unexpected drive word expected none got dir=%0b duty=%0d",
                     $time, rsp_direction_forward, rsp_drive_duty);
            mismatches++;
         end else begin
            want = pending_drive.pop_front();
            if (rsp_direction_forward !== want.forward) begin
               $display("%0t: direction_forward expected %0b got %0b",
                        $time, want.forward, rsp_direction_forward);
               mismatches++;
            end
            if (rsp_drive_duty !== want.duty) begin
               $display("%0t: drive_duty expected %0d got %0d",
                        $time, want.duty, rsp_drive_duty);
               mismatches++;
            end
            words_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < WINDOW; i++) window_mem[i] = '0;
      window_total = 0;
      window_pos = 0;
      heading_fwd = 1'b0;
      drive_now = 0;
      drive_sent = 0;
      ramping = 1'b0;
      since_step = '0;
      cfg_step = 12'd40;
      cfg_interval = 20'd1000;
      cfg_dz_low = -13'sd50;
      cfg_dz_high = 12'd150;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_power_up();
      test_fast_ramp_clamp();
      test_zero_step();
      test_inverted_deadzone();
      test_backpressure();
      test_random_mix();

      req_valid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("tb: %0d joystick words in, %0d drive words checked, %0d register settings",
               words_sent, words_checked, settings_used);
      $display("tb: covered deadzone extremes, clamped decel, zero step and long stalls");
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
